### src/gradient_norm_clipper_core_assert.svh
// assertion macros for the gradient norm clipper
`ifndef GRADIENT_NORM_CLIPPER_CORE_ASSERT_SVH
`define GRADIENT_NORM_CLIPPER_CORE_ASSERT_SVH
// implication checked on every rising clock edge outside reset
`define GNC_ASSERT_IMP(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("gnc check failed");
// next-cycle implication
`define GNC_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("gnc check failed");
`endif

### src/gnc_pkg.sv
// shared types and constants for the gradient norm clipper
package gnc_pkg;
  localparam int unsigned MaxElements = 64;
  localparam int unsigned AddrW = $clog2(MaxElements);
  localparam int unsigned CntW = AddrW + 1;
  localparam logic [30:0] ClipReset = 31'd65536;

  typedef struct packed {
    logic signed [31:0] grad_value;
    logic               is_final;
  } in_word_t;

  typedef struct packed {
    logic signed [31:0] clipped_value;
    logic               end_of_run;
    logic               was_scaled;
    logic               dropped_any;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic clear;
    logic sqrt_start;
    logic sqrt_step;
    logic div_start;
    logic div_step;
    logic rd_en;
    logic [AddrW-1:0] rd_addr;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [CntW-1:0] count;
    logic            full;
    logic            scale;
  } dp_status_t;
endpackage

### src/gnc_ram.sv
// generic single port write, registered read ram
module gnc_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end
endmodule

### src/gnc_datapath.sv
// store, square sum, iterative square root and divider
module gnc_datapath (
  input  logic                clk,
  input  logic                rst,
  input  gnc_pkg::dp_cmd_t    cmd,
  input  logic signed [31:0]  in_value,
  input  logic [30:0]         clip_norm,
  output gnc_pkg::dp_status_t status,
  output logic [31:0]         result,
  output logic [31:0]         scaled
);
  import gnc_pkg::*;

  logic [CntW-1:0] count;
  logic [63:0]     square_sum;
  logic [31:0]     mag_in;
  logic [63:0]     sq;
  logic [64:0]     sum_wide;
  logic [63:0]     sum_next;
  logic [31:0]     rd_data;

  // square root state
  logic [63:0] s_rem, s_res, s_bit;
  logic [31:0] norm;
  logic [64:0] s_try;

  // divider state
  logic [63:0] d_num;
  logic [31:0] d_quo;
  logic [32:0] d_rem;
  logic [33:0] d_try;
  logic [5:0]  d_idx;
  logic [31:0] mag_rd;
  logic [63:0] prod;
  logic        rd_neg;

  assign mag_in = in_value[31] ? (32'd0 - in_value) : in_value;
  assign sq = 64'(mag_in) * 64'(mag_in);
  assign sum_wide = {1'b0, square_sum} + {1'b0, sq};
  // saturate at all ones
  assign sum_next = sum_wide[64] ? '1 : sum_wide[63:0];

  gnc_ram #(.Width(32), .Depth(MaxElements)) u_store (
    .clk(clk), .we(cmd.load), .waddr(count[AddrW-1:0]), .wdata(in_value),
    .re(cmd.rd_en), .raddr(cmd.rd_addr), .rdata(rd_data)
  );

  assign status.count = count;
  assign status.full = (count == CntW'(MaxElements));
  assign status.scale = ({1'b0, norm} > {2'b0, clip_norm});

  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      count <= '0;
      square_sum <= '0;
    end else if (cmd.load) begin
      count <= count + 1'b1;
      square_sum <= sum_next;
    end
  end

  // one root bit per step, 32 steps
  // the final word may be summed in the same cycle the root starts
  assign s_try = {1'b0, s_res} + {1'b0, s_bit};
  always_ff @(posedge clk) begin
    if (cmd.sqrt_start) begin
      s_rem <= cmd.load ? sum_next : square_sum;
      s_res <= '0;
      s_bit <= 64'h4000_0000_0000_0000;
    end else if (cmd.sqrt_step) begin
      if ({1'b0, s_rem} >= s_try) begin
        s_rem <= s_rem - s_try[63:0];
        s_res <= (s_res >> 1) + s_bit;
      end else begin
        s_res <= s_res >> 1;
      end
      s_bit <= s_bit >> 2;
    end
  end
  assign norm = s_res[31:0];

  // restoring divide, one quotient bit per step over 64 numerator bits
  assign mag_rd = rd_data[31] ? (32'd0 - rd_data) : rd_data;
  assign prod = 64'(mag_rd) * 64'(clip_norm);
  assign d_try = {d_rem, d_num[6'd63 - d_idx]} - {2'b0, norm};
  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      d_num <= prod;
      d_rem <= '0;
      d_quo <= '0;
      d_idx <= '0;
      rd_neg <= rd_data[31];
      result <= rd_data;
    end else if (cmd.div_step) begin
      if (!d_try[33]) begin
        d_rem <= d_try[32:0];
        d_quo <= {d_quo[30:0], 1'b1};
      end else begin
        d_rem <= {d_rem[31:0], d_num[6'd63 - d_idx]};
        d_quo <= {d_quo[30:0], 1'b0};
      end
      d_idx <= d_idx + 1'b1;
    end
  end

  // final quotient with sign restored, valid after 64 steps
  assign scaled = rd_neg ? (32'd0 - d_quo) : d_quo;
endmodule

### src/gnc_ctrl.sv
// controller sequencing load, root, divide and emit
module gnc_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  input  logic                in_final,
  output logic                in_ready,
  output gnc_pkg::dp_cmd_t    cmd,
  input  gnc_pkg::dp_status_t status,
  output logic                out_load,
  output logic                out_scaled_sel,
  output logic                out_last,
  output logic                dropped,
  output logic                scale_q,
  input  logic                out_free
);
  import gnc_pkg::*;

  typedef enum logic [2:0] {
    S_LOAD, S_SQRT, S_READ, S_PREP, S_DIV, S_PUSH
  } state_t;

  state_t          state;
  logic [5:0]      step;
  logic [AddrW-1:0] idx;
  logic [CntW-1:0]  n;

  assign in_ready = (state == S_LOAD);

  always_comb begin
    cmd = '0;
    cmd.load = (state == S_LOAD) && in_valid && !status.full;
    cmd.sqrt_start = (state == S_LOAD) && in_valid && in_final;
    cmd.sqrt_step = (state == S_SQRT);
    cmd.rd_en = (state == S_READ);
    cmd.rd_addr = idx;
    cmd.div_start = (state == S_PREP);
    cmd.div_step = (state == S_DIV);
    cmd.clear = (state == S_PUSH) && out_free && (CntW'(idx) + 1'b1 == n);
  end

  assign out_load = (state == S_PUSH) && out_free;
  assign out_scaled_sel = scale_q;
  assign out_last = (CntW'(idx) + 1'b1 == n);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_LOAD;
      dropped <= 1'b0;
      step <= '0;
      idx <= '0;
      n <= '0;
      scale_q <= 1'b0;
    end else begin
      unique case (state)
        S_LOAD: begin
          if (in_valid) begin
            if (status.full) dropped <= 1'b1;
            if (in_final) begin
              state <= S_SQRT;
              step <= '0;
              n <= status.full ? status.count : status.count + 1'b1;
            end
          end
        end
        S_SQRT: begin
          step <= step + 1'b1;
          if (step == 6'd31) begin
            state <= S_READ;
            idx <= '0;
          end
        end
        S_READ: begin
          scale_q <= status.scale;
          state <= S_PREP;
        end
        S_PREP: begin
          step <= '0;
          state <= scale_q ? S_DIV : S_PUSH;
        end
        S_DIV: begin
          step <= step + 1'b1;
          if (step == 6'd63) state <= S_PUSH;
        end
        S_PUSH: begin
          if (out_free) begin
            if (CntW'(idx) + 1'b1 == n) begin
              state <= S_LOAD;
              dropped <= 1'b0;
            end else begin
              idx <= idx + 1'b1;
              state <= S_READ;
            end
          end
        end
        default: state <= S_LOAD;
      endcase
    end
  end
endmodule

### src/gradient_norm_clipper_core.sv
// top level of the gradient l2 norm clipper
//  channel | dir | handshake           | word
//  in      | in  | in_valid/in_ready   | gnc_pkg::in_word_t
//  out     | out | out_valid/out_ready | gnc_pkg::out_word_t
//  cfg     | in  | cfg_valid/cfg_ready | clip_norm, 31 bits
// elements load one per cycle while in_ready is high; the final word
// starts the square root, then each stored element is read and emitted,
// after a divide when the norm exceeds clip_norm (one quotient bit a cycle)
// synchronous active high reset clears counts, flags and output valid
// an empty output register or out_ready frees the emit stage; input stalls
// while a vector is processed
module gradient_norm_clipper_core (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  gnc_pkg::in_word_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output gnc_pkg::out_word_t out_data,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [30:0]        cfg_data
);
  import gnc_pkg::*;

  logic [30:0] clip_norm;
  dp_cmd_t     cmd;
  dp_status_t  status;
  logic [31:0] raw_value;
  logic [31:0] scaled_value;
  logic [31:0] emit_value;
  logic        out_load, scaled_sel, out_last, dropped, scale_q, out_free;

  // configuration register, always writable
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) clip_norm <= ClipReset;
    else if (cfg_valid) clip_norm <= cfg_data;
  end

  gnc_datapath u_dp (
    .clk(clk), .rst(rst), .cmd(cmd), .in_value(in_data.grad_value),
    .clip_norm(clip_norm), .status(status), .result(raw_value),
    .scaled(scaled_value)
  );

  gnc_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_final(in_data.is_final),
    .in_ready(in_ready), .cmd(cmd), .status(status), .out_load(out_load),
    .out_scaled_sel(scaled_sel), .out_last(out_last), .dropped(dropped),
    .scale_q(scale_q), .out_free(out_free)
  );

  // scaled value from the divider quotient, else the stored element
  assign emit_value = scaled_sel ? scaled_value : raw_value;

  // output register
  assign out_free = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end
  always_ff @(posedge clk) begin
    if (out_load) begin
      out_data.clipped_value <= emit_value;
      out_data.end_of_run <= out_last;
      out_data.was_scaled <= scale_q;
      out_data.dropped_any <= dropped;
    end
  end

  `include "gradient_norm_clipper_core_assert.svh"
  `GNC_ASSERT_IMP(a_no_in_while_busy, clk, rst, out_load, !in_ready)
  `GNC_ASSERT_NEXT(a_out_after_load, clk, rst, out_load, out_valid)
  `GNC_ASSERT_IMP(a_count_bound, clk, rst, 1'b1, status.count <= CntW'(MaxElements))
endmodule

### tb/tb_gradient_norm_clipper_core.sv
// self-checking testbench for the gradient l2 norm clipper core
module tb_gradient_norm_clipper_core;
  import gnc_pkg::*;

  localparam int unsigned CycleLimit = 3000000;
  // quiet time before a clip_norm write; covers the root pass of a final word
  localparam int unsigned SettleCycles = 60;

  logic        clk;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  in_word_t    in_data;
  logic        out_valid;
  logic        out_ready;
  out_word_t   out_data;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [30:0] cfg_data;

  gradient_norm_clipper_core i_dut (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  // 10 unit clock
  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  // words waiting for the driver, and clipped words the block owes us
  in_word_t    grad_words[$];
  out_word_t   owed_words[$];

  // predictor state, shadowing the block
  logic [31:0] shadow_store[MaxElements];
  int unsigned shadow_count;
  logic [63:0] shadow_sum;
  logic        shadow_dropped;
  logic [30:0] shadow_clip;

  int unsigned err_count;
  int unsigned cycle_count;
  int unsigned vectors_done;
  int unsigned scaled_vectors;
  int unsigned dropped_vectors;
  int unsigned words_checked;
  int unsigned words_sent;
  int unsigned random_sent;

  // knobs the stimulus uses to shape idling
  logic        no_idle;
  logic        long_hold_req;
  logic        long_hold_done;
  int unsigned send_gap;
  int unsigned hold_left;

  task automatic report_mismatch(input string what, input logic [31:0] exp_v,
                                 input logic [31:0] got_v);
    $display("mismatch %s: expected %h got %h (word %0d)", what, exp_v, got_v,
             words_checked);
    err_count++;
  endtask

  // floor square root, one result bit at a time from the top
  function automatic logic [63:0] floor_root(input logic [63:0] v);
    logic [63:0] acc;
    logic [63:0] trial;
    acc = '0;
    for (int i = 31; i >= 0; i--) begin
      trial = acc | (64'd1 << i);
      if (trial * trial <= v) acc = trial;
    end
    return acc;
  endfunction

  function automatic logic [32:0] abs_of(input logic [31:0] v);
    return v[31] ? ({1'b0, ~v} + 33'd1) : {1'b0, v};
  endfunction

  // absorb one accepted gradient word; on the final one queue the clipped vector
  function automatic void absorb_grad_word(input in_word_t w);
    logic [63:0] sq;
    logic [63:0] norm;
    logic [63:0] quot;
    logic        scale;
    out_word_t   o;
    if (shadow_count < MaxElements) begin
      sq = abs_of(w.grad_value) * abs_of(w.grad_value);
      shadow_store[shadow_count] = w.grad_value;
      shadow_count++;
      if (shadow_sum > ~64'd0 - sq) shadow_sum = ~64'd0;
      else shadow_sum = shadow_sum + sq;
    end else begin
      shadow_dropped = 1'b1;
    end
    if (!w.is_final) return;
    norm  = floor_root(shadow_sum);
    scale = norm > {33'd0, shadow_clip};
    for (int k = 0; k < shadow_count; k++) begin
      o.clipped_value = shadow_store[k];
      if (scale) begin
        quot = (abs_of(shadow_store[k]) * {33'd0, shadow_clip}) / norm;
        o.clipped_value = shadow_store[k][31] ? -quot[31:0] : quot[31:0];
      end
      o.end_of_run  = (k + 1 == shadow_count);
      o.was_scaled  = scale;
      o.dropped_any = shadow_dropped;
      owed_words.push_back(o);
    end
    vectors_done++;
    if (scale) scaled_vectors++;
    if (shadow_dropped) dropped_vectors++;
    shadow_count   = 0;
    shadow_sum     = '0;
    shadow_dropped = 1'b0;
  endfunction

  // mostly short gaps, a few long ones
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (no_idle || r < 55) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // driver: hands queued words to the block, idles between them
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data  <= '0;
      send_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        absorb_grad_word(in_data);
        words_sent++;
      end
      if (!in_valid || in_ready) begin
        if (send_gap > 0) begin
          send_gap <= send_gap - 1;
          in_valid <= 1'b0;
        end else if (grad_words.size() > 0) begin
          in_data  <= grad_words.pop_front();
          in_valid <= 1'b1;
          send_gap <= pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver: random stalls plus one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      out_ready      <= 1'b0;
      hold_left      <= 0;
      long_hold_done <= 1'b0;
    end else if (hold_left > 0) begin
      hold_left <= hold_left - 1;
      out_ready <= 1'b0;
    end else if (long_hold_req && !long_hold_done) begin
      hold_left      <= 400;
      long_hold_done <= 1'b1;
      out_ready      <= 1'b0;
    end else if (no_idle) begin
      out_ready <= 1'b1;
    end else if ($urandom_range(0, 99) < 6) begin
      hold_left <= $urandom_range(8, 40);
      out_ready <= 1'b0;
    end else begin
      out_ready <= $urandom_range(0, 99) < 70;
    end
  end

  // monitor: clip_norm writes and clipped words
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) shadow_clip = cfg_data;
      if (out_valid && out_ready) begin
        if (owed_words.size() == 0) begin
          $display("unexpected clipped word %h", out_data);
          err_count++;
        end else begin
          out_word_t e;
          e = owed_words.pop_front();
          if (out_data.clipped_value !== e.clipped_value)
            report_mismatch("clipped_value", e.clipped_value, out_data.clipped_value);
          if (out_data.end_of_run !== e.end_of_run)
            report_mismatch("end_of_run", e.end_of_run, out_data.end_of_run);
          if (out_data.was_scaled !== e.was_scaled)
            report_mismatch("was_scaled", e.was_scaled, out_data.was_scaled);
          if (out_data.dropped_any !== e.dropped_any)
            report_mismatch("dropped_any", e.dropped_any, out_data.dropped_any);
        end
        words_checked++;
      end
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words still owed", cycle_count,
               owed_words.size());
      $display("DONE: errors detected");
      $finish;
    end
  end

  // element values: small, extreme or fully random
  function automatic logic [31:0] pick_grad();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return $urandom_range(0, 32'h3ffff) - 32'h20000;
    if (r < 55) return 32'h8000_0000;
    if (r < 62) return 32'h7fff_ffff;
    if (r < 67) return 32'h0;
    return $urandom;
  endfunction

  // queue one vector; the last word carries is_final
  task automatic queue_vector(input int unsigned len, input logic [31:0] fixed_v,
                              input logic use_fixed);
    in_word_t w;
    for (int i = 0; i < len; i++) begin
      w.grad_value = use_fixed ? fixed_v : pick_grad();
      w.is_final   = (i == len - 1);
      grad_words.push_back(w);
    end
  endtask

  task automatic wait_drained();
    while (grad_words.size() > 0 || in_valid || owed_words.size() > 0)
      @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_clip(input logic [30:0] v);
    wait_drained();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
  endtask

  // random vectors: mostly short, some long; the last one is cut to the budget
  task automatic queue_random(input int unsigned n_words);
    int unsigned r;
    int unsigned len;
    int unsigned start;
    int unsigned left;
    start = random_sent;
    while (random_sent - start < n_words) begin
      r = $urandom_range(0, 99);
      if (r < 75) len = $urandom_range(1, 12);
      else if (r < 85) len = $urandom_range(13, 63);
      else if (r < 92) len = MaxElements;
      else len = $urandom_range(MaxElements + 1, MaxElements + 6);
      left = n_words - (random_sent - start);
      if (len > left) len = left;
      queue_vector(len, '0, 1'b0);
      random_sent += len;
    end
  endtask

  initial begin
    rst            = 1'b1;
    in_valid       = 1'b0;
    in_data        = '0;
    out_ready      = 1'b0;
    cfg_valid      = 1'b0;
    cfg_data       = '0;
    no_idle        = 1'b0;
    long_hold_req  = 1'b0;
    err_count      = 0;
    cycle_count    = 0;
    vectors_done   = 0;
    scaled_vectors = 0;
    dropped_vectors = 0;
    words_checked  = 0;
    words_sent     = 0;
    random_sent    = 0;
    shadow_count   = 0;
    shadow_sum     = '0;
    shadow_dropped = 1'b0;
    shadow_clip    = ClipReset;
    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // directed, reset clip_norm: extremes, single element, zero vector,
    // saturating sum from five most negative words
    queue_vector(1, 32'h7fff_ffff, 1'b1);
    queue_vector(2, 32'h8000_0000, 1'b1);
    queue_vector(1, 32'h0000_8000, 1'b1);
    queue_vector(3, 32'h0, 1'b1);
    queue_vector(5, 32'h8000_0000, 1'b1);
    queue_vector(2, 32'h0001_0000, 1'b1);
    queue_vector(3, 32'hffff_0001, 1'b1);
    // vector running past the store capacity
    queue_vector(MaxElements + 2, '0, 1'b0);

    // clip_norm of zero scales any nonzero vector to zero
    write_clip(31'd0);
    queue_vector(2, 32'h0000_0001, 1'b1);
    queue_vector(2, 32'h0, 1'b1);

    // clip_norm of one and the largest clip_norm
    write_clip(31'd1);
    queue_random(20);
    write_clip(31'h7fff_ffff);
    queue_vector(4, 32'h8000_0000, 1'b1);
    queue_random(15);

    // back-pressure: receiver holds off while the sender keeps offering
    write_clip(31'd65536);
    long_hold_req = 1'b1;
    queue_random(25);

    // no idling on either side
    wait_drained();
    no_idle = 1'b1;
    queue_random(15);
    wait_drained();
    no_idle = 1'b0;

    for (int p = 0; p < 3; p++) begin
      write_clip(31'($urandom_range(1, 32'h0008_0000)) |
                 ((p == 2) ? 31'h5555_0000 : 31'd0));
      queue_random(15);
    end
    write_clip(31'($urandom));
    queue_random(15);

    wait_drained();
    $display("sent %0d words (%0d random) in %0d vectors; checked %0d clipped words",
             words_sent, random_sent, vectors_done, words_checked);
    $display("%0d vectors scaled, %0d vectors lost elements past capacity",
             scaled_vectors, dropped_vectors);
    if (err_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### files.f
+incdir+src
src/gnc_pkg.sv
src/gnc_ram.sv
src/gnc_datapath.sv
src/gnc_ctrl.sv
src/gradient_norm_clipper_core.sv
tb/tb_gradient_norm_clipper_core.sv
